[hw/rtl/tmu_pkg.sv]
// Shared types, constants and helpers for the third-moment tensor entry update unit.
`timescale 1ns / 1ps
`default_nettype none
package tmu_pkg;

	// Topic count ceiling and register reset values
	localparam int          MAX_TOPICS    = 64;
	localparam int          TOPIC_W       = 7;
	localparam logic [6:0]  TOPICS_RESET  = 7'd64;
	localparam logic [31:0] ONE_Q24       = 32'h0100_0000;
	localparam logic [31:0] ALPHA_RESET   = ONE_Q24;

	// Configuration port widths and register indexes
	localparam int         CFG_IW         = 1;
	localparam int         CFG_DW         = 32;
	localparam logic [0:0] REG_NUM_TOPICS = 1'b0;
	localparam logic [0:0] REG_ALPHA_SUM  = 1'b1;

	// Datapath sizes
	localparam int MUL_LAT = 5;             // signed 64x64 multiplier depth
	localparam int DIV_QW  = 62;            // quotient bits of the scale divider
	localparam int DIV_NW  = DIV_QW + 3;    // numerator bits
	localparam int DIV_DW  = 49;            // divisor bits
	localparam int DIV_LAT = DIV_QW + 1;    // one bit a stage plus rounding
	localparam int TERM_W  = 80;            // width of the exact sum
	localparam int ACC_LAT = 5;             // round, three adder levels, saturate

	// Pipeline stage numbers, counted from the input register
	localparam int ST_IN   = 1;
	localparam int ST_PAIR = ST_IN + 1;
	localparam int ST_Q    = ST_PAIR + MUL_LAT + 1;
	localparam int ST_N    = ST_IN + MUL_LAT;
	localparam int ST_S    = ST_N + DIV_LAT;
	localparam int ST_P    = ST_S + MUL_LAT;
	localparam int ST_OUT  = ST_P + ACC_LAT;

	// Product terms handed to the accumulator
	localparam int NUM_TERMS  = 10;
	localparam int TM_TRI_WWW = 0;   // s3*Wi*Wj*Wl
	localparam int TM_TRI_WWM = 1;   // s2*Wi*Wj*Ml
	localparam int TM_TRI_WMW = 2;   // s2*Wi*Wl*Mj
	localparam int TM_TRI_MWW = 3;   // s2*Wj*Wl*Mi
	localparam int TM_DUO_IML = 4;   // s2*Wi*Ml
	localparam int TM_DUO_IWL = 5;   // s3*Wi*Wl
	localparam int TM_DUO_IMJ = 6;   // s2*Wi*Mj
	localparam int TM_DUO_IWJ = 7;   // s3*Wi*Wj
	localparam int TM_DUO_MIJ = 8;   // s2*Mi*Wj
	localparam int TM_DIAG    = 9;   // 2*s3*Wi

	typedef struct packed {
		logic [5:0]         row_index;
		logic [5:0]         mid_index;
		logic [5:0]         last_index;
		logic signed [31:0] w_row;
		logic signed [31:0] w_mid;
		logic signed [31:0] w_last;
		logic signed [31:0] m_row;
		logic signed [31:0] m_mid;
		logic signed [31:0] m_last;
		logic [15:0]        doc_length;
		logic signed [63:0] acc_in;
	} sample_t;

	typedef struct packed {
		logic signed [63:0] acc_out;
		logic [5:0]         row_out;
		logic [11:0]        col_out;
		logic               applied;
		logic               saturated;
	} result_t;

	// Per-entry data carried beside the arithmetic
	typedef struct packed {
		logic signed [63:0] acc;
		logic [5:0]         row;
		logic [11:0]        col;
		logic               applied;
		logic               eq_ij;
		logic               eq_il;
		logic               eq_jl;
		logic               eq_all;
	} meta_t;

	// Round to nearest, ties up, then arithmetic shift right
	function automatic logic signed [127:0] rnd_sar(input logic signed [127:0] x,
			input int unsigned sh);
		logic signed [127:0] half;
		half = 128'sd1 <<< (sh - 1);
		return (x + half) >>> sh;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/tmu_if.sv]
// Valid/ready channel interfaces for entry words and result words.
`timescale 1ns / 1ps
`default_nettype none
interface tmu_sample_if;
	import tmu_pkg::*;
	logic    valid;
	logic    ready;
	sample_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface tmu_result_if;
	import tmu_pkg::*;
	logic    valid;
	logic    ready;
	result_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hw/rtl/third_moment_tensor_entry_update_unit.sv]
// Throughput: one entry word per cycle; the whole pipeline advances together and
// holds while the output register holds a word that is not taken.
// The depth is set by the 62-stage radix-2 dividers for the scale factors s3 and s2.
// Reset clears all valid bits and loads num_topics = 64, alpha_sum = 1.0.
`timescale 1ns / 1ps
`default_nettype none
module third_moment_tensor_entry_update_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [tmu_pkg::CFG_IW-1:0] cfg_index,
	input  wire logic [tmu_pkg::CFG_DW-1:0] cfg_data,
	tmu_sample_if.sink                      sample,
	tmu_result_if.source                    result
);
	import tmu_pkg::*;

	logic [TOPIC_W-1:0] num_topics_q;
	logic [31:0]        alpha_q;
	logic [ST_OUT:1]    vld_q;
	logic               en, accept;

	sample_t            smp;
	logic [TOPIC_W-1:0] k_eff;
	logic [12:0]        col_full;
	meta_t              meta_c;

	logic signed [31:0] wi_s1, wj_s1, wl_s1, mi_s1, mj_s1, ml_s1;
	logic [15:0]        len_s1;
	meta_t              meta_s1;

	logic signed [63:0] wiwj_s2, wiwl_s2, wjwl_s2, wiml_s2, wimj_s2, miwj_s2;
	logic signed [31:0] wl_s2, ml_s2, mj_s2, mi_s2;
	logic [31:0]        ll_s2;
	logic [15:0]        lm2_s2;
	logic [DIV_DW-1:0]  d3_s3;
	logic [32:0]        d2_s3;

	logic [DIV_DW+32:0] den_dly;
	logic signed [127:0] n3_p, n2_p;
	logic [DIV_QW-1:0]  s3_q, s2_q;

	logic signed [127:0] tri_p [4];
	logic signed [63:0]  q_s8 [4];
	logic [255:0]        q_dly;
	logic [319:0]        duo_dly;
	logic [31:0]         wi_dly;
	logic [$bits(meta_t)-1:0] meta_dly;

	logic signed [63:0]  s3v, s2v;
	logic signed [127:0] prod [NUM_TERMS];
	result_t             res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_topics_q <= TOPICS_RESET;
			alpha_q      <= ALPHA_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_TOPICS: num_topics_q <= cfg_data[TOPIC_W-1:0];
				REG_ALPHA_SUM:  alpha_q      <= cfg_data;
				default:        ;
			endcase
		end
	end

	// Advance the whole pipeline unless the output word is held
	assign en           = !vld_q[ST_OUT] || result.ready;
	assign accept       = sample.valid && en;
	assign sample.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[ST_OUT-1:1], accept};
		end
	end

	// Address, range check and index coincidences
	assign smp      = sample.payload;
	assign k_eff    = (num_topics_q > TOPIC_W'(MAX_TOPICS)) ? TOPIC_W'(MAX_TOPICS)
		: num_topics_q;
	assign col_full = 13'(k_eff) * 13'(smp.mid_index) + 13'(smp.last_index);

	always_comb begin
		meta_c.acc     = smp.acc_in;
		meta_c.row     = smp.row_index;
		meta_c.col     = col_full[11:0];
		meta_c.applied = (smp.doc_length > 16'd2)
			&& ({1'b0, smp.row_index} < k_eff)
			&& ({1'b0, smp.mid_index} < k_eff)
			&& ({1'b0, smp.last_index} < k_eff);
		meta_c.eq_ij   = smp.mid_index == smp.row_index;
		meta_c.eq_il   = smp.last_index == smp.row_index;
		meta_c.eq_jl   = smp.mid_index == smp.last_index;
		meta_c.eq_all  = (smp.mid_index == smp.row_index)
			&& (smp.last_index == smp.row_index);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// input register
			wi_s1   <= smp.w_row;
			wj_s1   <= smp.w_mid;
			wl_s1   <= smp.w_last;
			mi_s1   <= smp.m_row;
			mj_s1   <= smp.m_mid;
			ml_s1   <= smp.m_last;
			len_s1  <= smp.doc_length;
			meta_s1 <= meta_c;
			// exact pair products
			wiwj_s2 <= wi_s1 * wj_s1;
			wiwl_s2 <= wi_s1 * wl_s1;
			wjwl_s2 <= wj_s1 * wl_s1;
			wiml_s2 <= wi_s1 * ml_s1;
			wimj_s2 <= wi_s1 * mj_s1;
			miwj_s2 <= mi_s1 * wj_s1;
			wl_s2   <= wl_s1;
			ml_s2   <= ml_s1;
			mj_s2   <= mj_s1;
			mi_s2   <= mi_s1;
			// divisors 2L(L-1) and 2L(L-1)(L-2)
			ll_s2   <= len_s1 * (len_s1 - 16'd1);
			lm2_s2  <= len_s1 - 16'd2;
			d2_s3   <= {ll_s2, 1'b0};
			d3_s3   <= {ll_s2, 1'b0} * lm2_s2;
		end
	end

	// Divisors wait for the numerator multipliers
	tmu_delay #(.W(DIV_DW + 33), .N(MUL_LAT - 2)) u_den_dly (
		.clk(clk), .en(en), .d({d3_s3, d2_s3}), .q(den_dly)
	);

	// Numerators (a+1)(a+2) and a(a+1) in Q.48
	tmu_mul u_num3 (
		.clk(clk), .en(en),
		.a($signed({32'd0, alpha_q} + {32'd0, ONE_Q24})),
		.b($signed({32'd0, alpha_q} + {31'd0, ONE_Q24, 1'b0})),
		.p(n3_p)
	);
	tmu_mul u_num2 (
		.clk(clk), .en(en),
		.a($signed({32'd0, alpha_q})),
		.b($signed({32'd0, alpha_q} + {32'd0, ONE_Q24})),
		.p(n2_p)
	);

	tmu_div u_div3 (
		.clk(clk), .en(en), .num(n3_p[DIV_NW-1:0]),
		.den(den_dly[DIV_DW+32:33]), .quo(s3_q)
	);
	tmu_div u_div2 (
		.clk(clk), .en(en), .num(n2_p[DIV_NW-1:0]),
		.den(DIV_DW'(den_dly[32:0])), .quo(s2_q)
	);

	// Triple products: pair times third value
	tmu_mul u_tri0 (.clk(clk), .en(en), .a(wiwj_s2), .b(64'(wl_s2)), .p(tri_p[0]));
	tmu_mul u_tri1 (.clk(clk), .en(en), .a(wiwj_s2), .b(64'(ml_s2)), .p(tri_p[1]));
	tmu_mul u_tri2 (.clk(clk), .en(en), .a(wiwl_s2), .b(64'(mj_s2)), .p(tri_p[2]));
	tmu_mul u_tri3 (.clk(clk), .en(en), .a(wjwl_s2), .b(64'(mi_s2)), .p(tri_p[3]));

	// Round triple products to Q.48
	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < 4; n++) begin
				q_s8[n] <= 64'(rnd_sar(tri_p[n], 36));
			end
		end
	end

	// Hold operands until the scale factors arrive
	tmu_delay #(.W(256), .N(ST_S - ST_Q)) u_q_dly (
		.clk(clk), .en(en), .d({q_s8[0], q_s8[1], q_s8[2], q_s8[3]}), .q(q_dly)
	);
	tmu_delay #(.W(320), .N(ST_S - ST_PAIR)) u_duo_dly (
		.clk(clk), .en(en),
		.d({wiml_s2, wiwl_s2, wimj_s2, wiwj_s2, miwj_s2}), .q(duo_dly)
	);
	tmu_delay #(.W(32), .N(ST_S - ST_IN)) u_wi_dly (
		.clk(clk), .en(en), .d(wi_s1), .q(wi_dly)
	);
	tmu_delay #(.W($bits(meta_t)), .N(ST_P - ST_IN)) u_meta_dly (
		.clk(clk), .en(en), .d(meta_s1), .q(meta_dly)
	);

	assign s3v = $signed({2'b00, s3_q});
	assign s2v = $signed({2'b00, s2_q});

	// Scale every term by s3 or s2
	tmu_mul u_m0 (.clk(clk), .en(en), .a(s3v), .b($signed(q_dly[255:192])),
		.p(prod[TM_TRI_WWW]));
	tmu_mul u_m1 (.clk(clk), .en(en), .a(s2v), .b($signed(q_dly[191:128])),
		.p(prod[TM_TRI_WWM]));
	tmu_mul u_m2 (.clk(clk), .en(en), .a(s2v), .b($signed(q_dly[127:64])),
		.p(prod[TM_TRI_WMW]));
	tmu_mul u_m3 (.clk(clk), .en(en), .a(s2v), .b($signed(q_dly[63:0])),
		.p(prod[TM_TRI_MWW]));
	tmu_mul u_m4 (.clk(clk), .en(en), .a(s2v), .b($signed(duo_dly[319:256])),
		.p(prod[TM_DUO_IML]));
	tmu_mul u_m5 (.clk(clk), .en(en), .a(s3v), .b($signed(duo_dly[255:192])),
		.p(prod[TM_DUO_IWL]));
	tmu_mul u_m6 (.clk(clk), .en(en), .a(s2v), .b($signed(duo_dly[191:128])),
		.p(prod[TM_DUO_IMJ]));
	tmu_mul u_m7 (.clk(clk), .en(en), .a(s3v), .b($signed(duo_dly[127:64])),
		.p(prod[TM_DUO_IWJ]));
	tmu_mul u_m8 (.clk(clk), .en(en), .a(s2v), .b($signed(duo_dly[63:0])),
		.p(prod[TM_DUO_MIJ]));
	tmu_mul u_m9 (.clk(clk), .en(en), .a(s3v), .b(64'($signed(wi_dly))),
		.p(prod[TM_DIAG]));

	tmu_acc u_acc (
		.clk(clk), .en(en), .prod(prod), .meta(meta_t'(meta_dly)), .res(res)
	);

	assign result.valid   = vld_q[ST_OUT];
	assign result.payload = res;
endmodule
`default_nettype wire

[hw/rtl/tmu_delay.sv]
// Enabled shift-register delay line for pipeline side data.
`timescale 1ns / 1ps
`default_nettype none
module tmu_delay #(
	parameter int W = 8,
	parameter int N = 1
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);
	logic [W-1:0] line_q [N];

	// Advance the line on every enabled cycle
	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int k = 1; k < N; k++) begin
				line_q[k] <= line_q[k-1];
			end
		end
	end

	assign q = line_q[N-1];
endmodule
`default_nettype wire

[hw/rtl/tmu_mul.sv]
// Pipelined signed 64x64 multiplier built from four 32x32 partial products.
`timescale 1ns / 1ps
`default_nettype none
module tmu_mul (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic signed [63:0]  a,
	input  wire logic signed [63:0]  b,
	output logic signed      [127:0] p
);
	import tmu_pkg::*;

	logic [63:0]          ua_s1, ub_s1;
	logic                 neg_s1, neg_s2, neg_s3, neg_s4;
	logic [63:0]          p00_s2, p01_s2, p10_s2, p11_s2;
	logic [64:0]          mid_s3;
	logic [127:0]         lo_s3, mag_s4;
	logic signed [127:0]  p_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			// take magnitudes
			ua_s1  <= a[63] ? (~a + 64'd1) : a;
			ub_s1  <= b[63] ? (~b + 64'd1) : b;
			neg_s1 <= a[63] ^ b[63];
			// partial products
			p00_s2 <= ua_s1[31:0]  * ub_s1[31:0];
			p01_s2 <= ua_s1[31:0]  * ub_s1[63:32];
			p10_s2 <= ua_s1[63:32] * ub_s1[31:0];
			p11_s2 <= ua_s1[63:32] * ub_s1[63:32];
			neg_s2 <= neg_s1;
			// fold the cross terms
			mid_s3 <= 65'(p01_s2) + 65'(p10_s2);
			lo_s3  <= {p11_s2, p00_s2};
			neg_s3 <= neg_s2;
			// full magnitude
			mag_s4 <= lo_s3 + ({63'd0, mid_s3} << 32);
			neg_s4 <= neg_s3;
			// restore sign
			p_s5   <= neg_s4 ? $signed(~mag_s4 + 128'd1) : $signed(mag_s4);
		end
	end

	assign p = p_s5;
endmodule
`default_nettype wire

[hw/rtl/tmu_div.sv]
// Radix-2 pipelined divider with round-to-nearest quotient, one bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module tmu_div (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [tmu_pkg::DIV_NW-1:0] num,
	input  wire logic [tmu_pkg::DIV_DW-1:0] den,
	output logic      [tmu_pkg::DIV_QW-1:0] quo
);
	import tmu_pkg::*;

	logic [DIV_DW-1:0] rem_q [DIV_QW];
	logic [DIV_DW-1:0] den_q [DIV_QW];
	logic [DIV_QW-1:0] low_q [DIV_QW];
	logic [DIV_QW-1:0] quo_q [DIV_QW];
	logic [DIV_QW-1:0] rnd_q;

	for (genvar k = 0; k < DIV_QW; k++) begin : g_stage
		logic [DIV_DW-1:0] rem_i, den_i;
		logic [DIV_QW-1:0] low_i, quo_i;
		logic [DIV_DW:0]   trial;
		logic              take;

		if (k == 0) begin : g_first
			// top numerator bits stay below any valid divisor
			assign rem_i = DIV_DW'(num[DIV_NW-1:DIV_QW]);
			assign low_i = num[DIV_QW-1:0];
			assign quo_i = '0;
			assign den_i = den;
		end else begin : g_next
			assign rem_i = rem_q[k-1];
			assign low_i = low_q[k-1];
			assign quo_i = quo_q[k-1];
			assign den_i = den_q[k-1];
		end

		// bring down one bit and try the subtract
		assign trial = {rem_i, low_i[DIV_QW-1]};
		assign take  = trial >= {1'b0, den_i};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= take ? DIV_DW'(trial - {1'b0, den_i}) : trial[DIV_DW-1:0];
				low_q[k] <= {low_i[DIV_QW-2:0], 1'b0};
				quo_q[k] <= {quo_i[DIV_QW-2:0], take};
				den_q[k] <= den_i;
			end
		end
	end

	// round half up on the final remainder
	always_ff @(posedge clk) begin
		if (en) begin
			rnd_q <= quo_q[DIV_QW-1]
				+ DIV_QW'({rem_q[DIV_QW-1], 1'b0} >= {1'b0, den_q[DIV_QW-1]});
		end
	end

	assign quo = rnd_q;
endmodule
`default_nettype wire

[hw/rtl/tmu_acc.sv]
// Rounds the scaled terms, sums them with the entry value and saturates.
`timescale 1ns / 1ps
`default_nettype none
module tmu_acc (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic signed [127:0]    prod [tmu_pkg::NUM_TERMS],
	input  wire tmu_pkg::meta_t         meta,
	output tmu_pkg::result_t            res
);
	import tmu_pkg::*;

	localparam int unsigned RSH [NUM_TERMS] = '{48, 48, 48, 48, 56, 56, 56, 56, 56, 27};
	localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;

	logic signed [TERM_W-1:0] t_s1 [NUM_TERMS];
	logic signed [TERM_W-1:0] a_s2 [6];
	logic signed [TERM_W-1:0] b_s3 [3];
	logic signed [TERM_W-1:0] c_s4;
	meta_t                    meta_s1, meta_s2, meta_s3, meta_s4;
	logic signed [TERM_W-1:0] rnd_c [NUM_TERMS];
	logic                     fits;
	result_t                  res_q;

	// Round each product to Q.48
	always_comb begin
		for (int n = 0; n < NUM_TERMS; n++) begin
			rnd_c[n] = TERM_W'(rnd_sar(prod[n], RSH[n]));
		end
	end

	assign fits = (c_s4[TERM_W-1:63] == {(TERM_W-63){c_s4[63]}});

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= rnd_c;
			meta_s1 <= meta;
			// first level, coincidence terms gated by index matches
			a_s2[0] <= TERM_W'(meta_s1.acc) + t_s1[TM_TRI_WWW];
			a_s2[1] <= -t_s1[TM_TRI_WWM] - t_s1[TM_TRI_WMW];
			a_s2[2] <= meta_s1.eq_ij ? (t_s1[TM_DUO_IML] - t_s1[TM_DUO_IWL]
				- t_s1[TM_TRI_MWW]) : -t_s1[TM_TRI_MWW];
			a_s2[3] <= meta_s1.eq_il ? (t_s1[TM_DUO_IMJ] - t_s1[TM_DUO_IWJ]) : '0;
			a_s2[4] <= meta_s1.eq_jl ? (t_s1[TM_DUO_MIJ] - t_s1[TM_DUO_IWJ]) : '0;
			a_s2[5] <= meta_s1.eq_all ? t_s1[TM_DIAG] : '0;
			meta_s2 <= meta_s1;
			// second level
			b_s3[0] <= a_s2[0] + a_s2[1];
			b_s3[1] <= a_s2[2] + a_s2[3];
			b_s3[2] <= a_s2[4] + a_s2[5];
			meta_s3 <= meta_s2;
			// third level
			c_s4    <= b_s3[0] + b_s3[1] + b_s3[2];
			meta_s4 <= meta_s3;
			// saturate, or pass the entry through when not applied
			res_q.row_out <= meta_s4.row;
			res_q.col_out <= meta_s4.col;
			res_q.applied <= meta_s4.applied;
			if (!meta_s4.applied) begin
				res_q.acc_out   <= meta_s4.acc;
				res_q.saturated <= 1'b0;
			end else if (fits) begin
				res_q.acc_out   <= c_s4[63:0];
				res_q.saturated <= 1'b0;
			end else begin
				res_q.acc_out   <= c_s4[TERM_W-1] ? ACC_MIN : ACC_MAX;
				res_q.saturated <= 1'b1;
			end
		end
	end

	assign res = res_q;
endmodule
`default_nettype wire

[hw/rtl/tmu_check.sv]
// Port-level checks for the tensor entry update unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tmu_check (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_ready,
	input wire logic             r_valid,
	input wire logic             r_ready,
	input wire tmu_pkg::result_t r_payload
);
	import tmu_pkg::*;

	// hold a result word that is not taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_payload))
		else $error("result word changed while stalled");

	// never refuse input while the output register is empty
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!r_valid |-> s_ready)
		else $error("input stalled with empty output");

	// saturation only on an applied update
	a_sat_applied: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_payload.saturated |-> r_payload.applied)
		else $error("saturated without applied");

	// a clipped value sits at a range limit
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_payload.saturated |->
			(r_payload.acc_out == 64'sh7FFF_FFFF_FFFF_FFFF)
			|| (r_payload.acc_out == 64'sh8000_0000_0000_0000))
		else $error("saturated value off the range limit");
endmodule

bind third_moment_tensor_entry_update_unit tmu_check u_tmu_check (
	.clk(clk),
	.arst_n(arst_n),
	.s_ready(sample.ready),
	.r_valid(result.valid),
	.r_ready(result.ready),
	.r_payload(result.payload)
);
`default_nettype wire
